// ===== rtl/core/orbit_camera_eye_update_top_assert.svh =====
// assertion macros for the orbit camera eye update checker
`ifndef ORBIT_CAMERA_EYE_UPDATE_TOP_ASSERT_SVH
`define ORBIT_CAMERA_EYE_UPDATE_TOP_ASSERT_SVH

// implication in the same cycle, sampled on clk, off during rst
`define OCU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication into the next cycle, sampled on clk, off during rst
`define OCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ocu_pkg.sv =====
// types, constants and tables shared by the orbit camera eye update block
`timescale 1ns / 1ps
`default_nettype none

package ocu_pkg;

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EL_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EL_MAX = 2'd2;

  // reset values
  localparam logic [15:0] RADIUS_RST   = 16'd2560;
  localparam logic [15:0] EL_MIN_RST   = 16'd1820;
  localparam logic [15:0] EL_MAX_RST   = 16'd30948;
  localparam logic [15:0] EL_ANGLE_RST = 16'd16384;
  localparam logic [15:0] AZ_ANGLE_RST = 16'd0;

  // key vector magnitudes, q1.15
  localparam logic [15:0] MAG_AXIS = 16'd32768;
  localparam logic [15:0] MAG_DIAG = 16'd23170;

  // binary angle landmarks
  localparam logic [15:0] ANG_QUARTER = 16'd16384;
  localparam logic [15:0] ANG_THREE_Q = 16'd49152;
  localparam logic [15:0] ANG_HALF    = 16'h8000;

  // cordic vector width and start value, q4.30
  localparam int CORDIC_W = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic signed [16:0] EYE_LIMIT = 17'sd65535;

  // datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE     = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;
  localparam op_t OP_STEP_MUL = 4'd2;
  localparam op_t OP_ANGLE    = 4'd3;
  localparam op_t OP_CLAMP    = 4'd4;
  localparam op_t OP_CINIT    = 4'd5;
  localparam op_t OP_CITER    = 4'd6;
  localparam op_t OP_CDONE    = 4'd7;
  localparam op_t OP_MUL_SC   = 4'd8;
  localparam op_t OP_MUL_R    = 4'd9;
  localparam op_t OP_X_SS     = 4'd10;
  localparam op_t OP_Z_CR     = 4'd11;
  localparam op_t OP_OUT      = 4'd12;

  typedef struct packed {
    op_t  op;
    logic sel_az;
  } cmd_t;

  typedef struct packed {
    logic has_keys;
    logic iter_last;
    logic out_free;
  } sts_t;

  // arctangent of 2^-i, full turn at 2^32
  function automatic logic signed [CORDIC_W-1:0] atan_q32(input logic [4:0] idx);
    logic signed [CORDIC_W-1:0] v;
    case (idx)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10680862;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ocu_in_if.sv =====
// request channel carrying the key state and frame time
`timescale 1ns / 1ps
`default_nettype none

interface ocu_in_if ();
  logic        valid;
  logic        ready;
  logic        key_up;
  logic        key_down;
  logic        key_left;
  logic        key_right;
  logic [15:0] frame_time;

  modport source (output valid, key_up, key_down, key_left, key_right, frame_time,
                  input ready);
  modport sink (input valid, key_up, key_down, key_left, key_right, frame_time,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ocu_out_if.sv =====
// result channel carrying the eye position and moved flag
`timescale 1ns / 1ps
`default_nettype none

interface ocu_out_if ();
  logic               valid;
  logic               ready;
  logic signed [16:0] eye_x;
  logic signed [16:0] eye_y;
  logic signed [16:0] eye_z;
  logic               moved;

  modport source (output valid, eye_x, eye_y, eye_z, moved, input ready);
  modport sink (input valid, eye_x, eye_y, eye_z, moved, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ocu_ctrl.sv =====
// sequencing state machine for the orbit camera eye update
`timescale 1ns / 1ps
`default_nettype none

module ocu_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ocu_pkg::sts_t sts,
  output ocu_pkg::cmd_t cmd
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_SMUL    = 4'd1;
  localparam logic [3:0] ST_ANG     = 4'd2;
  localparam logic [3:0] ST_CLAMP   = 4'd3;
  localparam logic [3:0] ST_EL_INIT = 4'd4;
  localparam logic [3:0] ST_EL_ITER = 4'd5;
  localparam logic [3:0] ST_EL_DONE = 4'd6;
  localparam logic [3:0] ST_AZ_INIT = 4'd7;
  localparam logic [3:0] ST_AZ_ITER = 4'd8;
  localparam logic [3:0] ST_AZ_DONE = 4'd9;
  localparam logic [3:0] ST_M0      = 4'd10;
  localparam logic [3:0] ST_M1      = 4'd11;
  localparam logic [3:0] ST_M2      = 4'd12;
  localparam logic [3:0] ST_M3      = 4'd13;
  localparam logic [3:0] ST_M4      = 4'd14;
  localparam logic [3:0] ST_OUT     = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = ocu_pkg::OP_NONE;
    cmd.sel_az = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = ocu_pkg::OP_LOAD;
          state_next = ST_SMUL;
        end
      end
      ST_SMUL: begin
        if (sts.has_keys) begin
          cmd.op     = ocu_pkg::OP_STEP_MUL;
          state_next = ST_ANG;
        end else begin
          state_next = ST_EL_INIT;
        end
      end
      ST_ANG: begin
        cmd.op     = ocu_pkg::OP_ANGLE;
        state_next = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.op     = ocu_pkg::OP_CLAMP;
        state_next = ST_EL_INIT;
      end
      ST_EL_INIT: begin
        cmd.op     = ocu_pkg::OP_CINIT;
        state_next = ST_EL_ITER;
      end
      ST_EL_ITER: begin
        cmd.op = ocu_pkg::OP_CITER;
        if (sts.iter_last) begin
          state_next = ST_EL_DONE;
        end
      end
      ST_EL_DONE: begin
        cmd.op     = ocu_pkg::OP_CDONE;
        state_next = ST_AZ_INIT;
      end
      ST_AZ_INIT: begin
        cmd.op     = ocu_pkg::OP_CINIT;
        cmd.sel_az = 1'b1;
        state_next = ST_AZ_ITER;
      end
      ST_AZ_ITER: begin
        cmd.op = ocu_pkg::OP_CITER;
        if (sts.iter_last) begin
          state_next = ST_AZ_DONE;
        end
      end
      ST_AZ_DONE: begin
        cmd.op     = ocu_pkg::OP_CDONE;
        cmd.sel_az = 1'b1;
        state_next = ST_M0;
      end
      ST_M0: begin
        cmd.op     = ocu_pkg::OP_MUL_SC;
        state_next = ST_M1;
      end
      ST_M1: begin
        cmd.op     = ocu_pkg::OP_MUL_R;
        state_next = ST_M2;
      end
      ST_M2: begin
        cmd.op     = ocu_pkg::OP_X_SS;
        state_next = ST_M3;
      end
      ST_M3: begin
        cmd.op     = ocu_pkg::OP_MUL_R;
        state_next = ST_M4;
      end
      ST_M4: begin
        cmd.op     = ocu_pkg::OP_Z_CR;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.op     = ocu_pkg::OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign in_ready = (state == ST_IDLE);

endmodule

`default_nettype wire

// ===== rtl/core/ocu_datapath.sv =====
// angle update, shared cordic, shared multiplier and result register
`timescale 1ns / 1ps
`default_nettype none

module ocu_datapath #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  ocu_pkg::cmd_t      cmd,
  output ocu_pkg::sts_t      sts,
  input  logic               key_up,
  input  logic               key_down,
  input  logic               key_left,
  input  logic               key_right,
  input  logic [15:0]        frame_time,
  input  logic [15:0]        orbit_radius,
  input  logic [15:0]        elevation_min,
  input  logic [15:0]        elevation_max,
  input  logic               out_ready,
  output logic               out_valid,
  output logic signed [16:0] eye_x,
  output logic signed [16:0] eye_y,
  output logic signed [16:0] eye_z,
  output logic               moved
);

  localparam int ITER_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
  localparam int CW = ocu_pkg::CORDIC_W;

  // latched request
  logic        k_up, k_down, k_left, k_right;
  logic [15:0] ft;

  // angle state
  logic [15:0]        el, az;
  logic signed [17:0] ne_raw;
  logic [15:0]        na;
  logic               mv;

  // cordic
  logic signed [CW-1:0] cx, cy, cz;
  logic                 flip;
  logic [ITER_W-1:0]    cnt;
  logic signed [17:0]   s_el, c_el, s_az, c_az;

  // products
  logic signed [35:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [53:0] mul_p;
  logic signed [53:0] mreg;
  logic signed [16:0] ex, ez;

  logic               has_el, has_az;
  logic [15:0]        mag;
  logic [32:0]        step_sum;
  logic [16:0]        stepv;
  logic signed [17:0] el_delta, ne_sum, max_s, min_s, ne_hi, ne_cl;
  logic [15:0]        az_step;
  logic [15:0]        ang, ang_f;
  logic               flip_n;
  logic signed [CW-1:0] z0, shx, shy, at, xf, yf, c_full, s_full;
  logic signed [53:0] r30, r15;

  function automatic logic signed [16:0] sat17(input logic signed [53:0] v);
    logic signed [16:0] o;
    if (v > 54'sd65535) begin
      o = ocu_pkg::EYE_LIMIT;
    end else if (v < -54'sd65535) begin
      o = -ocu_pkg::EYE_LIMIT;
    end else begin
      o = v[16:0];
    end
    return o;
  endfunction

  assign has_el = k_up ^ k_down;
  assign has_az = k_left ^ k_right;
  assign mag    = (has_el && has_az) ? ocu_pkg::MAG_DIAG : ocu_pkg::MAG_AXIS;

  // one shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      ocu_pkg::OP_STEP_MUL: begin
        mul_a = {20'd0, mag};
        mul_b = {2'b00, ft};
      end
      ocu_pkg::OP_MUL_SC: begin
        mul_a = 36'(s_el);
        mul_b = c_az;
      end
      ocu_pkg::OP_MUL_R: begin
        mul_a = mreg[35:0];
        mul_b = {2'b00, orbit_radius};
      end
      ocu_pkg::OP_X_SS: begin
        mul_a = 36'(s_el);
        mul_b = s_az;
      end
      ocu_pkg::OP_Z_CR: begin
        mul_a = 36'(c_el);
        mul_b = {2'b00, orbit_radius};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // angle step, rounded
  assign step_sum = {1'b0, mreg[31:0]} + 33'd32768;
  assign stepv    = step_sum[32:16];

  always_comb begin
    if (k_up && !k_down) begin
      el_delta = signed'({1'b0, stepv});
    end else if (k_down && !k_up) begin
      el_delta = -signed'({1'b0, stepv});
    end else begin
      el_delta = '0;
    end
    if (k_left && !k_right) begin
      az_step = az + stepv[15:0];
    end else if (k_right && !k_left) begin
      az_step = az - stepv[15:0];
    end else begin
      az_step = az;
    end
  end

  assign ne_sum = signed'({2'b00, el}) + el_delta;

  // upper limit first, so the lower one wins on an inverted range
  assign max_s = signed'({2'b00, elevation_max});
  assign min_s = signed'({2'b00, elevation_min});
  assign ne_hi = (ne_raw > max_s) ? max_s : ne_raw;
  assign ne_cl = (ne_hi < min_s) ? min_s : ne_hi;

  // fold the left half plane onto the right one
  assign ang    = cmd.sel_az ? az : el;
  assign flip_n = (ang > ocu_pkg::ANG_QUARTER) && (ang < ocu_pkg::ANG_THREE_Q);
  assign ang_f  = flip_n ? (ang ^ ocu_pkg::ANG_HALF) : ang;
  assign z0     = CW'(signed'({ang_f, 16'd0}));

  assign shx = cx >>> cnt;
  assign shy = cy >>> cnt;
  assign at  = ocu_pkg::atan_q32(5'(cnt));

  assign xf     = flip ? -cx : cx;
  assign yf     = flip ? -cy : cy;
  assign c_full = (xf + 34'sd16384) >>> 15;
  assign s_full = (yf + 34'sd16384) >>> 15;

  assign r30 = (mreg + 54'sd536870912) >>> 30;
  assign r15 = (mreg + 54'sd16384) >>> 15;

  // architectural state and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      el        <= ocu_pkg::EL_ANGLE_RST;
      az        <= ocu_pkg::AZ_ANGLE_RST;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == ocu_pkg::OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == ocu_pkg::OP_CLAMP) begin
        el <= ne_cl[15:0];
        az <= na;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      ocu_pkg::OP_LOAD: begin
        k_up    <= key_up;
        k_down  <= key_down;
        k_left  <= key_left;
        k_right <= key_right;
        ft      <= frame_time;
        mv      <= 1'b0;
      end
      ocu_pkg::OP_STEP_MUL: begin
        mreg <= mul_p;
      end
      ocu_pkg::OP_ANGLE: begin
        ne_raw <= ne_sum;
        na     <= az_step;
      end
      ocu_pkg::OP_CLAMP: begin
        mv <= (ne_cl[15:0] != el) || (na != az);
      end
      ocu_pkg::OP_CINIT: begin
        cx   <= ocu_pkg::CORDIC_GAIN;
        cy   <= '0;
        cz   <= z0;
        flip <= flip_n;
        cnt  <= '0;
      end
      ocu_pkg::OP_CITER: begin
        if (!cz[CW-1]) begin
          cx <= cx - shy;
          cy <= cy + shx;
          cz <= cz - at;
        end else begin
          cx <= cx + shy;
          cy <= cy - shx;
          cz <= cz + at;
        end
        cnt <= cnt + 1'b1;
      end
      ocu_pkg::OP_CDONE: begin
        if (cmd.sel_az) begin
          c_az <= c_full[17:0];
          s_az <= s_full[17:0];
        end else begin
          c_el <= c_full[17:0];
          s_el <= s_full[17:0];
        end
      end
      ocu_pkg::OP_MUL_SC, ocu_pkg::OP_MUL_R: begin
        mreg <= mul_p;
      end
      ocu_pkg::OP_X_SS: begin
        ex   <= sat17(r30);
        mreg <= mul_p;
      end
      ocu_pkg::OP_Z_CR: begin
        ez   <= sat17(r30);
        mreg <= mul_p;
      end
      ocu_pkg::OP_OUT: begin
        eye_x <= ex;
        eye_y <= sat17(r15);
        eye_z <= ez;
        moved <= mv;
      end
      default: begin
      end
    endcase
  end

  assign sts.has_keys  = has_el || has_az;
  assign sts.iter_last = (cnt == ITER_LAST);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire

// ===== rtl/core/orbit_camera_eye_update_top.sv =====
// top level of the orbit camera eye update block
//
//   channel  dir   handshake       payload
//   keys     in    valid / ready   key_up key_down key_left key_right frame_time
//   eye      out   valid / ready   eye_x eye_y eye_z moved
//   cfg      in    cfg_we          cfg_index cfg_data (no read-back)
//
// a request is taken only in idle, so a new one waits until the last has passed
// every step, out to the result register; a request with no key skips the angle
// update; keys.ready and eye.valid rise together; the two cordic passes run one
// after the other on the single shared rotation unit
// the result sits in its own register, so keys.ready comes back while a
// result still waits on eye.ready; a stalled result holds the next one in
// the final step only
// rst is synchronous and active high; it restores the angles, the configuration registers, the sequencer and eye.valid
`timescale 1ns / 1ps
`default_nettype none

module orbit_camera_eye_update_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  ocu_in_if.sink                            keys,
  ocu_out_if.source                         eye,
  input  logic                              cfg_we,
  input  logic [ocu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [15:0]                       cfg_data
);

  // configuration registers
  logic [15:0] orbit_radius;
  logic [15:0] elevation_min;
  logic [15:0] elevation_max;

  ocu_pkg::cmd_t cmd;
  ocu_pkg::sts_t sts;

  // writes beyond the register list fall through and are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      orbit_radius  <= ocu_pkg::RADIUS_RST;
      elevation_min <= ocu_pkg::EL_MIN_RST;
      elevation_max <= ocu_pkg::EL_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        ocu_pkg::CFG_RADIUS: orbit_radius  <= cfg_data;
        ocu_pkg::CFG_EL_MIN: elevation_min <= cfg_data;
        ocu_pkg::CFG_EL_MAX: elevation_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // sequencer: steps the datapath through update, two cordic passes, products
  ocu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (keys.valid),
    .in_ready (keys.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: angle state, cordic, shared multiplier, result register
  ocu_datapath #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .key_up        (keys.key_up),
    .key_down      (keys.key_down),
    .key_left      (keys.key_left),
    .key_right     (keys.key_right),
    .frame_time    (keys.frame_time),
    .orbit_radius  (orbit_radius),
    .elevation_min (elevation_min),
    .elevation_max (elevation_max),
    .out_ready     (eye.ready),
    .out_valid     (eye.valid),
    .eye_x         (eye.eye_x),
    .eye_y         (eye.eye_y),
    .eye_z         (eye.eye_z),
    .moved         (eye.moved)
  );

endmodule

`default_nettype wire

// ===== rtl/core/ocu_checker.sv =====
// port-level checker for the orbit camera eye update block, with its bind
`timescale 1ns / 1ps
`default_nettype none

`include "orbit_camera_eye_update_top_assert.svh"

module ocu_checker (
  input logic               clk,
  input logic               rst,
  input logic               keys_valid,
  input logic               keys_ready,
  input logic               eye_valid,
  input logic               eye_ready,
  input logic signed [16:0] eye_x,
  input logic signed [16:0] eye_y,
  input logic signed [16:0] eye_z,
  input logic               eye_moved
);

  // an accepted request leaves the block busy in the next cycle
  `OCU_ASSERT_NEXT(a_busy_after_request, keys_valid && keys_ready, !keys_ready, "request taken while busy")

  // a result only appears out of a busy period
  `OCU_ASSERT_SAME(a_result_from_work, $rose(eye_valid), !$past(keys_ready), "result without work")

  // saturation never leaves the most negative code
  `OCU_ASSERT_SAME(a_eye_saturated, eye_valid, (eye_x != 17'h10000) && (eye_y != 17'h10000) && (eye_z != 17'h10000), "eye coordinate out of range")

  // a stalled result holds
  `OCU_ASSERT_NEXT(a_result_held, eye_valid && !eye_ready, eye_valid && $stable(eye_x) && $stable(eye_y) && $stable(eye_z) && $stable(eye_moved), "stalled result changed")

endmodule

bind orbit_camera_eye_update_top ocu_checker u_ocu_checker (
  .clk        (clk),
  .rst        (rst),
  .keys_valid (keys.valid),
  .keys_ready (keys.ready),
  .eye_valid  (eye.valid),
  .eye_ready  (eye.ready),
  .eye_x      (eye.eye_x),
  .eye_y      (eye.eye_y),
  .eye_z      (eye.eye_z),
  .eye_moved  (eye.moved)
);

`default_nettype wire
